>>> hw/rtl/rit_pkg.sv
// Package for the radix integer-to-text converter.
// Holds field widths, character constants, controller states and the
// command and status structs shared by the controller and the datapath.
package rit_pkg;

    localparam int VALUE_BITS = 64;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_BITS-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPECIAL,
        ST_DIVIDE,
        ST_STORE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic rd_start;
        logic rd_issue;
        logic out_digit;
        logic out_special;
    } t_dp_cmd;

    typedef struct packed {
        logic radix_bad;
        logic quot_zero;
        logic div_last;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

    // Maps a digit value (0 to 35) to its lowercase ASCII character.
    function automatic logic [CHAR_BITS-1:0] f_digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            ch = CHAR_ALPHA + CHAR_BITS'(d - DEC_DIGITS);
        end
        return ch;
    endfunction

endpackage

>>> hw/rtl/rit_in_if.sv
// Request channel of the converter: a value and its radix.
// Depends on rit_pkg for the field widths.
interface rit_in_if
    import rit_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

>>> hw/rtl/rit_out_if.sv
// Result channel of the converter: one ASCII character per transfer.
// Depends on rit_pkg for the field widths.
interface rit_out_if
    import rit_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 last;
    logic                 bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

>>> hw/rtl/rit_datapath.sv
// Datapath of the converter: shift-subtract divider, digit stack memory
// and the output register. Driven by rit_ctrl through t_dp_cmd; uses rit_pkg.
module rit_datapath
    import rit_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CHAR_BITS-1:0]  o_character,
    output logic                  o_last,
    output logic                  o_bad_radix
);

    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int BIT_W  = $clog2(VALUE_WIDTH);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] r_quot;
    logic [RADIX_BITS-1:0]  r_rem;
    logic [RADIX_BITS-1:0]  r_radix;
    logic [BIT_W-1:0]       r_bit;
    logic [CNT_W-1:0]       r_count;
    logic [ADDR_W-1:0]      r_rd_idx;
    logic [RADIX_BITS-1:0]  r_rd_data;
    logic                   r_rd_last;
    logic [RADIX_BITS-1:0]  r_mem [VALUE_WIDTH];

    logic                   r_out_valid;
    logic [CHAR_BITS-1:0]   r_char;
    logic                   r_last;
    logic                   r_bad;

    logic [RADIX_BITS:0]    w_trial;
    logic                   w_fits;
    logic                   w_radix_bad;
    logic                   w_out_free;

    assign w_trial     = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_fits      = (w_trial >= {1'b0, r_radix});
    assign w_radix_bad = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.radix_bad = w_radix_bad;
        o_sts.quot_zero = (r_quot == '0);
        o_sts.div_last  = (r_bit == '0);
        o_sts.rd_last   = r_rd_last;
        o_sts.out_free  = w_out_free;
    end

    // Divider and digit counter. One quotient bit per cycle, MSB first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= i_value[VALUE_WIDTH-1:0];
            r_radix <= i_radix;
            r_rem   <= '0;
            r_bit   <= BIT_TOP;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[VALUE_WIDTH-2:0], w_fits};
            r_rem  <= w_fits ? RADIX_BITS'(w_trial - {1'b0, r_radix})
                             : w_trial[RADIX_BITS-1:0];
            r_bit  <= r_bit - 1'b1;
        end else if (i_cmd.store_digit) begin
            r_rem   <= '0;
            r_bit   <= BIT_TOP;
            r_count <= r_count + 1'b1;
        end
    end

    // Digits are stacked least significant first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_digit) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_rem;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= r_count[ADDR_W-1:0];
        end else if (i_cmd.rd_issue) begin
            r_rd_idx  <= r_rd_idx - 1'b1;
            r_rd_last <= (r_rd_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_digit || i_cmd.out_special) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_digit) begin
            r_char <= f_digit_char(r_rd_data);
            r_last <= r_rd_last;
            r_bad  <= 1'b0;
        end else if (i_cmd.out_special) begin
            r_char <= w_radix_bad ? CHAR_NONE : CHAR_ZERO;
            r_last <= 1'b1;
            r_bad  <= w_radix_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;

endmodule

>>> hw/rtl/rit_ctrl.sv
// Controller of the converter: sequences division, digit storage and
// reverse emission. Uses t_state, t_dp_cmd and t_dp_sts from rit_pkg.
module rit_ctrl
    import rit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.radix_bad || i_sts.quot_zero) begin
                    n_state = ST_SPECIAL;
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_SPECIAL: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_DIVIDE: begin
                if (i_sts.div_last) n_state = ST_STORE;
            end
            ST_STORE: begin
                // The quotient now holds the value left after this digit.
                n_state = i_sts.quot_zero ? ST_READ : ST_DIVIDE;
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.rd_last ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_SPECIAL: begin
                o_cmd.out_special = i_sts.out_free;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_STORE: begin
                o_cmd.store_digit = 1'b1;
                o_cmd.rd_start    = i_sts.quot_zero;
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.out_digit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/radix_integer_to_text.sv
// Converts an unsigned integer to ASCII digits in radix 2 to 36, most
// significant digit first, with lowercase letters for digits 10 and up and
// the last mark on the final character. A radix outside 2 to 36 gives one
// result with character 0 and bad_radix set; a zero value gives one '0'.
// Only the low VALUE_WIDTH bits of value are used. One request is worked on
// at a time. Each digit is found by the shift-subtract divider, one quotient
// bit per cycle, and stacked; the digits are then read back from the digit
// stack in reverse order and emitted, stalling while the output is not free.
// The last result may wait in the output register while the next request is
// accepted.
module radix_integer_to_text
    import rit_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rit_in_if.sink     i_req,
    rit_out_if.source  o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    rit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rit_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (i_req.value),
        .i_radix     (i_req.radix),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_character (o_res.character),
        .o_last      (o_res.last),
        .o_bad_radix (o_res.bad_radix)
    );

endmodule
